// File: rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared types, arena geometry constants and result codes of the allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Arena geometry.
  localparam int ARENA_BYTES  = 65536;
  localparam int HEADER_BYTES = 40;
  localparam int ALIGN_BYTES  = 8;
  localparam int HDR_SPAN     = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int SLOTS        = ARENA_BYTES / ALIGN_BYTES;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int ALIGN_W      = $clog2(ALIGN_BYTES);
  localparam int TOP_W        = $clog2(ARENA_BYTES) + 1;

  // Result codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OOM     = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADR = 2'd2;

  // Request kinds.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] size;
    logic [15:0] addr;
  } ffa_req_t;

  typedef struct packed {
    logic [15:0] payload_addr;
    logic [1:0]  status;
  } ffa_rsp_t;

  // One header word, held per slot in the block memory.
  typedef struct packed {
    logic              mark;
    logic              free;
    logic              has_prev;
    logic [SLOT_W-1:0] prev;
    logic [15:0]       size;
  } ffa_blk_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_LF_RD,
    ST_LF_WR,
    ST_F_CHK,
    ST_F_PCHK,
    ST_F_PMRK,
    ST_F_NRD,
    ST_F_NCHK,
    ST_F_NMRK,
    ST_OUT
  } ffa_state_t;

endpackage

// File: rtl/core/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Manages a byte arena as address-ordered blocks with headers, allocates by
// first fit with splitting and frees with coalescing of free neighbors.
// ----------------------------------------------------------------------------
// One item is handled at a time by a small sequencer around a header
// memory with one write port and one registered read per cycle. After
// reset the block clears all 8192 header slots in turn and takes no item
// meanwhile. An allocate walks the block chain from address zero, reading
// and then checking each block header visited. A block that fits then has
// the remainder split off and the block after it relinked, while the top
// is grown or out of memory reported once the last header has been passed.
// ST_IDLE accepts the item and ST_OUT presents the result. A free checks
// the address and then the header, and a rejected address goes straight
// to the result; each merge with a neighbor adds a relink of the block that
// follows. The memory port is the limit on every step.
module first_fit_heap_allocator
  import ffa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ffa_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ffa_rsp_t out_data
);

  localparam logic [TOP_W-1:0]   SPAN_T  = TOP_W'(HDR_SPAN);
  localparam logic [TOP_W-1:0]   ARENA_T = TOP_W'(ARENA_BYTES);
  localparam logic [15:0]        SPAN_S  = 16'(HDR_SPAN);
  localparam logic [15:0]        SPLIT_MIN = 16'(HDR_SPAN + ALIGN_BYTES);
  localparam logic [TOP_W-1:0]   ALIGN_M = TOP_W'(ALIGN_BYTES - 1);

  // Header memory.
  ffa_blk_t mem [SLOTS];
  ffa_blk_t rdata_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [SLOT_W-1:0] mem_raddr;
  ffa_blk_t          mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // Sequencer registers.
  ffa_state_t state_r, state_nxt;
  logic [SLOT_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [TOP_W-1:0]  p_r, p_nxt;
  logic [TOP_W-1:0]  last_r, last_nxt;
  logic [TOP_W-1:0]  aligned_r, aligned_nxt;
  logic [SLOT_W-1:0] cur_slot_r, cur_slot_nxt;
  ffa_blk_t          cur_w_r, cur_w_nxt;
  ffa_blk_t          new_w_r, new_w_nxt;
  logic [SLOT_W-1:0] clr_slot_r, clr_slot_nxt;
  logic [TOP_W-1:0]  lf_end_r, lf_end_nxt;
  logic [SLOT_W-1:0] lf_prev_r, lf_prev_nxt;
  logic              lf_ret_r, lf_ret_nxt;
  ffa_rsp_t          res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      top_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      top_r     <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    last_r     <= last_nxt;
    aligned_r  <= aligned_nxt;
    cur_slot_r <= cur_slot_nxt;
    cur_w_r    <= cur_w_nxt;
    new_w_r    <= new_w_nxt;
    clr_slot_r <= clr_slot_nxt;
    lf_end_r   <= lf_end_nxt;
    lf_prev_r  <= lf_prev_nxt;
    lf_ret_r   <= lf_ret_nxt;
    res_r      <= res_nxt;
  end

  // Shared address arithmetic.
  logic [TOP_W-1:0] req_aligned;
  logic [15:0]      free_start;
  logic [TOP_W-1:0] cur_end;
  logic [TOP_W-1:0] walk_end;
  logic [TOP_W-1:0] split_at;
  logic [15:0]      rem;
  logic [15:0]      merged;

  assign req_aligned = ({1'b0, in_data.size} + ALIGN_M) & ~ALIGN_M;
  assign free_start  = in_data.addr - SPAN_S;
  assign cur_end     = {1'b0, cur_slot_r, {ALIGN_W{1'b0}}} + SPAN_T + {1'b0, cur_w_r.size};
  assign walk_end    = p_r + SPAN_T + {1'b0, rdata_r.size};
  assign split_at    = p_r + SPAN_T + aligned_r;
  assign rem         = rdata_r.size - aligned_r[15:0];
  assign merged      = cur_w_r.size + SPAN_S + rdata_r.size;

  // Next state, memory port and result.
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    top_nxt      = top_r;
    p_nxt        = p_r;
    last_nxt     = last_r;
    aligned_nxt  = aligned_r;
    cur_slot_nxt = cur_slot_r;
    cur_w_nxt    = cur_w_r;
    new_w_nxt    = new_w_r;
    clr_slot_nxt = clr_slot_r;
    lf_end_nxt   = lf_end_r;
    lf_prev_nxt  = lf_prev_r;
    lf_ret_nxt   = lf_ret_r;
    res_nxt      = res_r;
    mem_we       = 1'b0;
    mem_waddr    = cur_slot_r;
    mem_wdata    = cur_w_r;
    mem_raddr    = p_r[SLOT_W+ALIGN_W-1:ALIGN_W];

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {SLOT_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        mem_raddr = free_start[SLOT_W+ALIGN_W-1:ALIGN_W];
        if (in_valid) begin
          aligned_nxt  = req_aligned;
          p_nxt        = '0;
          last_nxt     = '0;
          cur_slot_nxt = free_start[SLOT_W+ALIGN_W-1:ALIGN_W];
          res_nxt      = '{payload_addr: 16'd0, status: STATUS_BAD_ADR};
          if (in_data.op == OP_ALLOC) begin
            state_nxt = ST_A_RD;
          end else if (in_data.addr < SPAN_S || {1'b0, free_start} >= top_r ||
                       free_start[ALIGN_W-1:0] != '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_F_CHK;
          end
        end
      end

      // Walk one block header per visit.
      ST_A_RD: begin
        if (p_r < top_r) begin
          state_nxt = ST_A_CHK;
        end else if ({1'b0, top_r} + {1'b0, SPAN_T} + {1'b0, aligned_r} >
                     {1'b0, ARENA_T}) begin
          res_nxt   = '{payload_addr: 16'd0, status: STATUS_OOM};
          state_nxt = ST_OUT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = top_r[SLOT_W+ALIGN_W-1:ALIGN_W];
          mem_wdata = '{mark: 1'b1, free: 1'b0, has_prev: (top_r != '0),
                        prev: last_r[SLOT_W+ALIGN_W-1:ALIGN_W], size: aligned_r[15:0]};
          res_nxt   = '{payload_addr: 16'(top_r + SPAN_T), status: STATUS_OK};
          top_nxt   = top_r + SPAN_T + aligned_r;
          state_nxt = ST_OUT;
        end
      end

      ST_A_CHK: begin
        if (rdata_r.free && {1'b0, rdata_r.size} >= aligned_r) begin
          mem_we    = 1'b1;
          mem_waddr = p_r[SLOT_W+ALIGN_W-1:ALIGN_W];
          mem_wdata = rdata_r;
          mem_wdata.free = 1'b0;
          res_nxt   = '{payload_addr: 16'(p_r + SPAN_T), status: STATUS_OK};
          if (rem >= SPLIT_MIN) begin
            mem_wdata.size = aligned_r[15:0];
            new_w_nxt  = '{mark: 1'b1, free: 1'b1, has_prev: 1'b1,
                           prev: p_r[SLOT_W+ALIGN_W-1:ALIGN_W], size: rem - SPAN_S};
            lf_prev_nxt = split_at[SLOT_W+ALIGN_W-1:ALIGN_W];
            lf_end_nxt  = walk_end;
            lf_ret_nxt  = 1'b0;
            state_nxt   = ST_A_SPLIT;
          end else begin
            state_nxt = ST_OUT;
          end
        end else begin
          last_nxt  = p_r;
          p_nxt     = walk_end;
          state_nxt = ST_A_RD;
        end
      end

      // Write the split-off remainder block.
      ST_A_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = lf_prev_r;
        mem_wdata = new_w_r;
        state_nxt = (lf_end_r < top_r) ? ST_LF_RD : ST_OUT;
      end

      // Relink the following block to its new predecessor.
      ST_LF_RD: begin
        mem_raddr = lf_end_r[SLOT_W+ALIGN_W-1:ALIGN_W];
        state_nxt = ST_LF_WR;
      end

      ST_LF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = lf_end_r[SLOT_W+ALIGN_W-1:ALIGN_W];
        mem_wdata = rdata_r;
        mem_wdata.prev     = lf_prev_r;
        mem_wdata.has_prev = 1'b1;
        state_nxt = lf_ret_r ? ST_F_NRD : ST_OUT;
      end

      // Free: validate the block and mark it free.
      ST_F_CHK: begin
        if (!rdata_r.mark || rdata_r.free) begin
          state_nxt = ST_OUT;
        end else begin
          res_nxt   = '{payload_addr: 16'd0, status: STATUS_OK};
          cur_w_nxt = rdata_r;
          cur_w_nxt.free = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = cur_w_nxt;
          if (rdata_r.has_prev) begin
            mem_raddr = rdata_r.prev;
            state_nxt = ST_F_PCHK;
          end else begin
            state_nxt = ST_F_NRD;
          end
        end
      end

      // Merge into a free predecessor.
      ST_F_PCHK: begin
        if (rdata_r.free) begin
          mem_we       = 1'b1;
          mem_waddr    = cur_w_r.prev;
          mem_wdata    = rdata_r;
          mem_wdata.size = merged;
          clr_slot_nxt = cur_slot_r;
          cur_slot_nxt = cur_w_r.prev;
          cur_w_nxt    = mem_wdata;
          state_nxt    = ST_F_PMRK;
        end else begin
          state_nxt = ST_F_NRD;
        end
      end

      ST_F_PMRK: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_slot_r;
        mem_wdata   = '0;
        lf_end_nxt  = cur_end;
        lf_prev_nxt = cur_slot_r;
        lf_ret_nxt  = 1'b1;
        state_nxt   = (cur_end < top_r) ? ST_LF_RD : ST_F_NRD;
      end

      // Look at the following block, or retract the top.
      ST_F_NRD: begin
        mem_raddr    = cur_end[SLOT_W+ALIGN_W-1:ALIGN_W];
        clr_slot_nxt = cur_end[SLOT_W+ALIGN_W-1:ALIGN_W];
        if (cur_end < top_r) begin
          state_nxt = ST_F_NCHK;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = cur_w_r;
          mem_wdata.mark = 1'b0;
          mem_wdata.free = 1'b0;
          top_nxt   = {1'b0, cur_slot_r, {ALIGN_W{1'b0}}};
          state_nxt = ST_OUT;
        end
      end

      ST_F_NCHK: begin
        if (rdata_r.free) begin
          cur_w_nxt = cur_w_r;
          cur_w_nxt.size = merged;
          mem_we    = 1'b1;
          mem_wdata = cur_w_nxt;
          state_nxt = ST_F_NMRK;
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_F_NMRK: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_slot_r;
        mem_wdata   = '0;
        lf_end_nxt  = cur_end;
        lf_prev_nxt = cur_slot_r;
        lf_ret_nxt  = 1'b0;
        state_nxt   = (cur_end < top_r) ? ST_LF_RD : ST_OUT;
      end

      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

  // Checks.
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("input and output open together");
  a_top_align: assert property (@(posedge clk) disable iff (!rst_n)
    top_r[ALIGN_W-1:0] == '0) else $error("heap top misaligned");
  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= ARENA_T) else $error("heap top past arena end");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_OOM ||
                   out_data.status == STATUS_BAD_ADR)) else $error("bad status code");

endmodule

// File: verif/tb_first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Sends allocate and free requests through the valid/stall handshake, with
// random gaps and output stalls. A behavioral copy of the arena bookkeeping
// predicts each response. The checker compares every response with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffa_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ffa_req_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ffa_rsp_t out_data;

  first_fit_heap_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock with a 20 ns period.
  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the arena headers, indexed by block start / ALIGN_BYTES.
  bit [15:0]       hdr_size [SLOTS];
  bit              hdr_free [SLOTS];
  bit              hdr_mark [SLOTS];
  bit [SLOT_W-1:0] hdr_prev [SLOTS];
  bit              hdr_has_prev [SLOTS];
  bit [TOP_W-1:0]  arena_top;

  ffa_rsp_t pending_rsp[$];
  int       live_addrs[$];
  int       errors = 0;
  int       n_alloc = 0;
  int       n_free = 0;
  int       n_oom = 0;
  int       n_bad = 0;
  int       n_rsp = 0;
  bit       no_gaps = 1'b0;

  function automatic int slot_of(int a);
    int s;
    s = a / ALIGN_BYTES;
    return (s < SLOTS) ? s : SLOTS - 1;
  endfunction

  function automatic int block_end(int start);
    return start + HDR_SPAN + int'(hdr_size[slot_of(start)]);
  endfunction

  // Point the block after this one back at it.
  function automatic void relink_next(int start);
    int nxt;
    nxt = block_end(start);
    if (nxt < int'(arena_top)) begin
      hdr_prev[slot_of(nxt)] = SLOT_W'(slot_of(start));
      hdr_has_prev[slot_of(nxt)] = 1'b1;
    end
  endfunction

  function automatic ffa_rsp_t alloc_result(int size);
    ffa_rsp_t r;
    int aligned, p, last, s, rem, np, n;
    aligned = ((size + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    p = 0;
    last = 0;
    r = '0;
    // First fit: walk the chain from address zero.
    while (p < int'(arena_top)) begin
      s = slot_of(p);
      if (hdr_free[s] && int'(hdr_size[s]) >= aligned) begin
        rem = int'(hdr_size[s]) - aligned;
        // Split off the tail when it can hold a header plus one word.
        if (rem >= HDR_SPAN + ALIGN_BYTES) begin
          np = p + HDR_SPAN + aligned;
          n = slot_of(np);
          hdr_size[n] = 16'(rem - HDR_SPAN);
          hdr_free[n] = 1'b1;
          hdr_mark[n] = 1'b1;
          hdr_prev[n] = SLOT_W'(s);
          hdr_has_prev[n] = 1'b1;
          hdr_size[s] = 16'(aligned);
          relink_next(np);
        end
        hdr_free[s] = 1'b0;
        r.payload_addr = 16'(p + HDR_SPAN);
        r.status = STATUS_OK;
        return r;
      end
      last = p;
      p = block_end(p);
    end
    // Nothing fits: grow the arena top, or report out of memory.
    if (int'(arena_top) + HDR_SPAN + aligned > ARENA_BYTES) begin
      r.status = STATUS_OOM;
      return r;
    end
    s = slot_of(int'(arena_top));
    hdr_size[s] = 16'(aligned);
    hdr_free[s] = 1'b0;
    hdr_mark[s] = 1'b1;
    hdr_prev[s] = SLOT_W'(slot_of(last));
    hdr_has_prev[s] = (arena_top != 0);
    r.payload_addr = 16'(int'(arena_top) + HDR_SPAN);
    r.status = STATUS_OK;
    arena_top = TOP_W'(int'(arena_top) + HDR_SPAN + aligned);
    return r;
  endfunction

  function automatic ffa_rsp_t free_result(int addr);
    ffa_rsp_t r;
    int start, s, ps, nxt, ns;
    r = '0;
    r.status = STATUS_BAD_ADR;
    if (addr < HDR_SPAN) return r;
    start = addr - HDR_SPAN;
    if (start >= int'(arena_top) || (start % ALIGN_BYTES) != 0) return r;
    s = slot_of(start);
    if (!hdr_mark[s] || hdr_free[s]) return r;
    r.status = STATUS_OK;
    hdr_free[s] = 1'b1;
    // Merge into a free predecessor.
    if (hdr_has_prev[s] && hdr_free[hdr_prev[s]]) begin
      ps = int'(hdr_prev[s]);
      hdr_size[ps] = 16'(int'(hdr_size[ps]) + HDR_SPAN + int'(hdr_size[s]));
      hdr_mark[s] = 1'b0;
      s = ps;
      start = ps * ALIGN_BYTES;
      relink_next(start);
    end
    // Absorb a free successor, or pull the top back if this is the last block.
    nxt = block_end(start);
    if (nxt < int'(arena_top)) begin
      ns = slot_of(nxt);
      if (hdr_free[ns]) begin
        hdr_size[s] = 16'(int'(hdr_size[s]) + HDR_SPAN + int'(hdr_size[ns]));
        hdr_mark[ns] = 1'b0;
        relink_next(start);
      end
    end else begin
      hdr_mark[s] = 1'b0;
      hdr_free[s] = 1'b0;
      arena_top = TOP_W'(start);
    end
    return r;
  endfunction

  // Send one item after a random gap; keeps valid high when no gap follows.
  task automatic send_request(logic op, int size, int addr);
    ffa_req_t req;
    ffa_rsp_t exp_rsp;
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.op = op;
    req.size = size[15:0];
    req.addr = addr[15:0];
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    if (op == OP_ALLOC) begin
      exp_rsp = alloc_result(size & 16'hFFFF);
      n_alloc++;
      if (exp_rsp.status == STATUS_OK) live_addrs.push_back(int'(exp_rsp.payload_addr));
      else n_oom++;
    end else begin
      exp_rsp = free_result(addr & 16'hFFFF);
      n_free++;
      if (exp_rsp.status == STATUS_OK) begin
        foreach (live_addrs[i])
          if (live_addrs[i] == addr) begin
            live_addrs.delete(i);
            break;
          end
      end else begin
        n_bad++;
      end
    end
    pending_rsp.push_back(exp_rsp);
  endtask

  // Stop sending until every expected response has arrived.
  task automatic drain_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
    errors++;
  endtask

  // Response checker with random output stalls.
  int stall_left = 0;
  always @(posedge clk) begin
    ffa_rsp_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response, status", int'(out_data.status), -1);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_data.status !== exp_rsp.status)
          report_mismatch("status", int'(out_data.status), int'(exp_rsp.status));
        if (out_data.payload_addr !== exp_rsp.payload_addr)
          report_mismatch("payload_addr", int'(out_data.payload_addr),
                          int'(exp_rsp.payload_addr));
      end
      stall_left = no_gaps ? 0 : $urandom_range(0, 10);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Growth, rounding, zero size and out of memory.
  task automatic test_alloc_basics();
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_ALLOC, 1, 16'hFFFF);
    send_request(OP_ALLOC, 16'hFFFF, 0);
    send_request(OP_ALLOC, 200, 0);
    send_request(OP_ALLOC, 16, 0);
    send_request(OP_ALLOC, 60000, 0);
  endtask

  // Every kind of rejected free, then a double free.
  task automatic test_bad_frees();
    send_request(OP_FREE, 0, 0);
    send_request(OP_FREE, 0, HDR_SPAN - 1);
    send_request(OP_FREE, 0, 129);
    send_request(OP_FREE, 0, 60000);
    send_request(OP_FREE, 16'hFFFF, 16'hFFFF);
    send_request(OP_FREE, 0, HDR_SPAN + ALIGN_BYTES);
    send_request(OP_FREE, 0, 128);
    send_request(OP_FREE, 0, 128);
  endtask

  // Split a freed block, then merge neighbors and shrink the top.
  task automatic test_split_and_merge();
    send_request(OP_ALLOC, 16, 0);
    send_request(OP_ALLOC, 100, 0);
    send_request(OP_FREE, 0, 80);
    send_request(OP_FREE, 0, 40);
    send_request(OP_FREE, 0, 128);
    send_request(OP_ALLOC, 8, 0);
    while (live_addrs.size() != 0) send_request(OP_FREE, 0, live_addrs[live_addrs.size() - 1]);
    drain_responses();
  endtask

  task automatic test_random_traffic(int count);
    int pick, size, addr;
    for (int i = 0; i < count; i++) begin
      // A stretch with no gaps on either side.
      no_gaps = (i >= count / 2 && i < count / 2 + 100);
      if (i == count / 3) drain_responses();
      pick = $urandom_range(0, 99);
      if (pick < 50 || live_addrs.size() == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 85) size = $urandom_range(0, 128);
        else if (pick < 96) size = $urandom_range(129, 2048);
        else size = $urandom_range(0, 16'hFFFF);
        send_request(OP_ALLOC, size, $urandom_range(0, 16'hFFFF));
      end else if (pick < 90) begin
        addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        send_request(OP_FREE, $urandom_range(0, 16'hFFFF), addr);
      end else begin
        // Broken frees: random, misaligned or near a live block.
        addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        pick = $urandom_range(0, 2);
        if (pick == 0) addr = $urandom_range(0, 16'hFFFF);
        else if (pick == 1) addr = addr + $urandom_range(1, 7);
        else addr = addr + ALIGN_BYTES * $urandom_range(1, 4);
        send_request(OP_FREE, $urandom_range(0, 16'hFFFF), addr);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Run limit.
  initial begin
    #1_000_000_000;
    $display("first_fit_heap_allocator: mismatch");
    $finish;
  end

  initial begin
    arena_top = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_alloc_basics();
    test_bad_frees();
    test_split_and_merge();
    test_random_traffic(1330);
    drain_responses();
    repeat (100) @(posedge clk);
    $display("Covered %0d allocates (%0d out of memory) and %0d frees (%0d rejected).",
             n_alloc, n_oom, n_free, n_bad);
    $display("Checked %0d responses with random gaps and output stalls.", n_rsp);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("first_fit_heap_allocator: match");
    end else begin
      $display("first_fit_heap_allocator: mismatch");
    end
    $finish;
  end

endmodule
